// ===== hw/rtl/pcp_pkg.sv =====
package pcp_pkg;

    localparam int CountW = 16;

    typedef logic [CountW-1:0] count_t;

    localparam count_t CountMax = '1;

    localparam logic [7:0] ChNine   = "9";
    localparam logic [7:0] ChZero   = "0";
    localparam logic [7:0] ChX      = "X";
    localparam logic [7:0] ChA      = "A";
    localparam logic [7:0] ChS      = "S";
    localparam logic [7:0] ChV      = "V";
    localparam logic [7:0] ChZ      = "Z";
    localparam logic [7:0] ChStar   = "*";
    localparam logic [7:0] ChPlus   = "+";
    localparam logic [7:0] ChMinus  = "-";
    localparam logic [7:0] ChComma  = ",";
    localparam logic [7:0] ChPeriod = ".";
    localparam logic [7:0] ChSlash  = "/";
    localparam logic [7:0] ChOpen   = "(";
    localparam logic [7:0] ChClose  = ")";
    localparam logic [7:0] ChLowA   = "a";
    localparam logic [7:0] ChLowZ   = "z";
    localparam logic [7:0] CaseGap  = 8'h20;

    typedef enum logic [2:0] {
        SYM_NINE,
        SYM_X,
        SYM_A,
        SYM_S,
        SYM_V,
        SYM_EDIT,
        SYM_OTHER
    } sym_t;

    typedef enum logic [1:0] {
        CLASS_ALNUM   = 2'd0,
        CLASS_NUMERIC = 2'd1,
        CLASS_ALPHA   = 2'd2,
        CLASS_EDITED  = 2'd3
    } class_t;

    typedef struct packed {
        class_t pic_class;
        count_t digits;
        count_t scale;
        logic   sign_seen;
        logic   after_point;
    } acc_t;

    localparam acc_t AccReset = '{
        pic_class:   CLASS_ALNUM,
        digits:      '0,
        scale:       '0,
        sign_seen:   1'b0,
        after_point: 1'b0
    };

    function automatic count_t sat_add(input count_t a, input count_t b);
        logic [CountW:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[CountW] ? CountMax : s[CountW-1:0];
    endfunction

    function automatic sym_t classify(input logic [7:0] c);
        sym_t k;
        case (c)
            ChNine:  k = SYM_NINE;
            ChX:     k = SYM_X;
            ChA:     k = SYM_A;
            ChS:     k = SYM_S;
            ChV:     k = SYM_V;
            ChZ, ChStar, ChPlus, ChMinus, ChComma, ChPeriod, ChSlash:
                     k = SYM_EDIT;
            default: k = SYM_OTHER;
        endcase
        return k;
    endfunction

    function automatic acc_t apply_sym(input acc_t a, input sym_t k, input count_t n);
        acc_t r;
        r = a;
        case (k)
            SYM_NINE:
            begin
                r.pic_class = CLASS_NUMERIC;
                if (a.after_point)
                    r.scale = sat_add(a.scale, n);
                else
                    r.digits = sat_add(a.digits, n);
            end
            SYM_X:
            begin
                r.pic_class = CLASS_ALNUM;
                r.digits    = sat_add(a.digits, n);
            end
            SYM_A:
            begin
                r.pic_class = CLASS_ALPHA;
                r.digits    = sat_add(a.digits, n);
            end
            SYM_S:    r.sign_seen   = 1'b1;
            SYM_V:    r.after_point = 1'b1;
            SYM_EDIT:
            begin
                r.pic_class = CLASS_EDITED;
                r.digits    = sat_add(a.digits, n);
            end
            default:  r = a;
        endcase
        return r;
    endfunction

endpackage

// ===== hw/rtl/picture_clause_parser_top.sv =====
// Channel  | Handshake             | Payload
// ---------+-----------------------+------------------------------------------------
// input    | sym_valid / sym_ready | symbol_char[7:0], last_char
// result   | res_valid / res_ready | pic_class[1:0], digit_count[15:0],
//          |                       | scale_count[15:0], has_sign, total_size[15:0]
//
// One character is taken per cycle while sym_ready is high; the parse state updates in the same cycle.
// A result appears in the output register in the cycle after its last character is taken.
// Characters that are not last are taken even while a result waits; a last
// character waits only while the output register is full and not being taken.
// rst_n clears the parse state and the output valid flag at once.
module picture_clause_parser_top (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 sym_valid,
    output logic                 sym_ready,
    input  logic [7:0]           symbol_char,
    input  logic                 last_char,
    output logic                 res_valid,
    input  logic                 res_ready,
    output logic [1:0]           pic_class,
    output pcp_pkg::count_t      digit_count,
    output pcp_pkg::count_t      scale_count,
    output logic                 has_sign,
    output pcp_pkg::count_t      total_size
);

    pcp_pkg::acc_t   acc_reg, acc_next;
    pcp_pkg::sym_t   pend_reg, pend_next;
    logic            pend_valid_reg, pend_valid_next;
    logic            in_rep_reg, in_rep_next;
    pcp_pkg::count_t rep_reg, rep_next;

    logic            res_valid_reg;
    pcp_pkg::acc_t   res_acc_reg, res_acc_next;

    logic            take;
    logic [7:0]      c_up;
    logic            is_digit;
    logic [pcp_pkg::CountW+3:0] rep_mul;
    pcp_pkg::count_t rep_sat;
    pcp_pkg::count_t final_n;

    assign sym_ready = !res_valid_reg || res_ready || !last_char;
    assign take      = sym_valid && sym_ready;

    always_comb
    begin
        c_up = symbol_char;
        if (symbol_char >= pcp_pkg::ChLowA && symbol_char <= pcp_pkg::ChLowZ)
            c_up = symbol_char - pcp_pkg::CaseGap;
    end

    assign is_digit = (c_up >= pcp_pkg::ChZero) && (c_up <= pcp_pkg::ChNine);

    // Repeat count times ten plus the new digit, done as two shifts and adds.
    always_comb
    begin
        rep_mul = ({4'b0, rep_reg} << 3) + ({4'b0, rep_reg} << 1)
                + {{pcp_pkg::CountW{1'b0}}, c_up[3:0] - pcp_pkg::ChZero[3:0]};
        rep_sat = (|rep_mul[pcp_pkg::CountW+3:pcp_pkg::CountW]) ? pcp_pkg::CountMax
                                                                 : rep_mul[pcp_pkg::CountW-1:0];
    end

    always_comb
    begin
        acc_next        = acc_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        in_rep_next     = in_rep_reg;
        rep_next        = rep_reg;
        res_acc_next    = acc_reg;
        final_n         = '0;

        if (in_rep_reg)
        begin
            if (is_digit)
                rep_next = rep_sat;
            else
            begin
                if (pend_valid_reg)
                    acc_next = pcp_pkg::apply_sym(acc_reg, pend_reg, rep_reg);
                pend_valid_next = 1'b0;
                in_rep_next     = 1'b0;
                rep_next        = '0;
                if (c_up != pcp_pkg::ChClose)
                begin
                    pend_next       = pcp_pkg::classify(c_up);
                    pend_valid_next = 1'b1;
                end
            end
        end
        else if (c_up == pcp_pkg::ChOpen && pend_valid_reg)
        begin
            in_rep_next = 1'b1;
            rep_next    = '0;
        end
        else
        begin
            if (pend_valid_reg)
                acc_next = pcp_pkg::apply_sym(acc_reg, pend_reg, pcp_pkg::count_t'(1));
            pend_next       = pcp_pkg::classify(c_up);
            pend_valid_next = 1'b1;
        end

        // The last character flushes the pending symbol and restarts the parse.
        if (last_char)
        begin
            final_n      = in_rep_next ? rep_next : pcp_pkg::count_t'(1);
            res_acc_next = pend_valid_next
                         ? pcp_pkg::apply_sym(acc_next, pend_next, final_n) : acc_next;
            acc_next        = pcp_pkg::AccReset;
            pend_valid_next = 1'b0;
            in_rep_next     = 1'b0;
            rep_next        = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg        <= pcp_pkg::AccReset;
            pend_valid_reg <= 1'b0;
            in_rep_reg     <= 1'b0;
            rep_reg        <= '0;
        end
        else if (take)
        begin
            acc_reg        <= acc_next;
            pend_valid_reg <= pend_valid_next;
            in_rep_reg     <= in_rep_next;
            rep_reg        <= rep_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
            pend_reg <= pend_next;
        if (take && last_char)
            res_acc_reg <= res_acc_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (take && last_char)
            res_valid_reg <= 1'b1;
        else if (res_ready)
            res_valid_reg <= 1'b0;
    end

    assign res_valid   = res_valid_reg;
    assign pic_class   = res_acc_reg.pic_class;
    assign digit_count = res_acc_reg.digits;
    assign scale_count = res_acc_reg.scale;
    assign has_sign    = res_acc_reg.sign_seen;
    assign total_size  = pcp_pkg::sat_add(res_acc_reg.digits,
                                          pcp_pkg::count_t'(res_acc_reg.sign_seen));

`ifndef SYNTHESIS
    a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (take && last_char) |=> res_valid)
        else $error("last character did not produce a result");

    a_last_clears_state: assert property (@(posedge clk) disable iff (!rst_n)
        (take && last_char) |=> (!pend_valid_reg && !in_rep_reg && rep_reg == '0))
        else $error("parse state not cleared after last character");

    a_repeat_has_symbol: assert property (@(posedge clk) disable iff (!rst_n)
        in_rep_reg |-> pend_valid_reg)
        else $error("repeat count open without a pending symbol");

    a_size_covers_digits: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (total_size >= digit_count))
        else $error("total size below digit count");
`endif

endmodule

// ===== tb/sv/picture_clause_parser_top_tb.sv =====
module picture_clause_parser_top_tb;

    typedef enum logic [1:0] {
        PACE_STEADY,
        PACE_SLOW_SRC,
        PACE_SLOW_SINK,
        PACE_BOTH
    } pace_t;

    typedef struct {
        logic [7:0] ch;
        logic       last;
        pace_t      pace;
    } pic_char_t;

    typedef struct {
        pcp_pkg::class_t cls;
        pcp_pkg::count_t digits;
        pcp_pkg::count_t scale;
        logic            sign;
        pcp_pkg::count_t size;
    } pic_summary_t;

    localparam int RandChars = 600;
    localparam int ShowLimit = 10;

    logic   clk         = 1'b0;
    logic   rst_n       = 1'b0;
    logic   sym_valid   = 1'b0;
    logic   sym_ready;
    logic   [7:0] symbol_char = '0;
    logic   last_char   = 1'b0;
    logic   res_valid;
    logic   res_ready   = 1'b0;
    logic   [1:0] pic_class;
    pcp_pkg::count_t digit_count;
    pcp_pkg::count_t scale_count;
    logic   has_sign;
    pcp_pkg::count_t total_size;

    pic_char_t    char_q[$];
    pic_summary_t summary_q[$];
    logic [7:0]   text_buf[$];
    pace_t        cur_pace       = PACE_STEADY;
    int           queued_total   = 0;
    int           accepted_total = 0;
    int           result_total   = 0;
    int           mismatch_total = 0;

    // Parse state of the predictor.
    pcp_pkg::sym_t   held_kind  = pcp_pkg::SYM_OTHER;
    logic            held_live  = 1'b0;
    logic            rpt_open   = 1'b0;
    pcp_pkg::count_t rpt_val    = '0;
    logic            past_point = 1'b0;
    pcp_pkg::count_t dig_acc    = '0;
    pcp_pkg::count_t scl_acc    = '0;
    logic            sign_flag  = 1'b0;
    pcp_pkg::class_t cls_acc    = pcp_pkg::CLASS_ALNUM;

    picture_clause_parser_top u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .sym_valid   (sym_valid),
        .sym_ready   (sym_ready),
        .symbol_char (symbol_char),
        .last_char   (last_char),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .pic_class   (pic_class),
        .digit_count (digit_count),
        .scale_count (scale_count),
        .has_sign    (has_sign),
        .total_size  (total_size)
    );

    always #5 clk = ~clk;

    function automatic pcp_pkg::count_t sat_sum(input pcp_pkg::count_t a,
                                                input pcp_pkg::count_t b);
        int unsigned s;
        s = a + b;
        return (s > pcp_pkg::CountMax) ? pcp_pkg::CountMax : pcp_pkg::count_t'(s);
    endfunction

    function automatic pcp_pkg::sym_t kind_of(input logic [7:0] c);
        case (c)
            pcp_pkg::ChNine:  return pcp_pkg::SYM_NINE;
            pcp_pkg::ChX:     return pcp_pkg::SYM_X;
            pcp_pkg::ChA:     return pcp_pkg::SYM_A;
            pcp_pkg::ChS:     return pcp_pkg::SYM_S;
            pcp_pkg::ChV:     return pcp_pkg::SYM_V;
            pcp_pkg::ChZ, pcp_pkg::ChStar, pcp_pkg::ChPlus, pcp_pkg::ChMinus,
            pcp_pkg::ChComma, pcp_pkg::ChPeriod, pcp_pkg::ChSlash:
                              return pcp_pkg::SYM_EDIT;
            default:          return pcp_pkg::SYM_OTHER;
        endcase
    endfunction

    function void fold_symbol(input pcp_pkg::sym_t k, input pcp_pkg::count_t n);
        case (k)
            pcp_pkg::SYM_NINE:
            begin
                cls_acc = pcp_pkg::CLASS_NUMERIC;
                if (past_point)
                    scl_acc = sat_sum(scl_acc, n);
                else
                    dig_acc = sat_sum(dig_acc, n);
            end
            pcp_pkg::SYM_X:
            begin
                cls_acc = pcp_pkg::CLASS_ALNUM;
                dig_acc = sat_sum(dig_acc, n);
            end
            pcp_pkg::SYM_A:
            begin
                cls_acc = pcp_pkg::CLASS_ALPHA;
                dig_acc = sat_sum(dig_acc, n);
            end
            pcp_pkg::SYM_S:
                sign_flag = 1'b1;
            pcp_pkg::SYM_V:
                past_point = 1'b1;
            pcp_pkg::SYM_EDIT:
            begin
                cls_acc = pcp_pkg::CLASS_EDITED;
                dig_acc = sat_sum(dig_acc, n);
            end
            default:
                ;
        endcase
    endfunction

    function void predict_char(input logic [7:0] raw, input logic last);
        logic [7:0]   c;
        int unsigned  v;
        pic_summary_t s;
        c = raw;
        if (c >= pcp_pkg::ChLowA && c <= pcp_pkg::ChLowZ)
            c = c - pcp_pkg::CaseGap;
        if (rpt_open)
        begin
            if (c >= pcp_pkg::ChZero && c <= pcp_pkg::ChNine)
            begin
                v = rpt_val * 10 + (c - pcp_pkg::ChZero);
                rpt_val = (v > pcp_pkg::CountMax) ? pcp_pkg::CountMax
                                                  : pcp_pkg::count_t'(v);
            end
            else
            begin
                // Any non-digit closes the count; only a close paren is swallowed.
                if (held_live)
                    fold_symbol(held_kind, rpt_val);
                held_live = 1'b0;
                rpt_open  = 1'b0;
                rpt_val   = '0;
                if (c != pcp_pkg::ChClose)
                begin
                    held_kind = kind_of(c);
                    held_live = 1'b1;
                end
            end
        end
        else if (c == pcp_pkg::ChOpen && held_live)
        begin
            rpt_open = 1'b1;
            rpt_val  = '0;
        end
        else
        begin
            if (held_live)
                fold_symbol(held_kind, pcp_pkg::count_t'(1));
            held_kind = kind_of(c);
            held_live = 1'b1;
        end
        if (last)
        begin
            if (held_live)
                fold_symbol(held_kind, rpt_open ? rpt_val : pcp_pkg::count_t'(1));
            s.cls    = cls_acc;
            s.digits = dig_acc;
            s.scale  = scl_acc;
            s.sign   = sign_flag;
            s.size   = sat_sum(dig_acc, pcp_pkg::count_t'(sign_flag));
            summary_q.push_back(s);
            held_kind  = pcp_pkg::SYM_OTHER;
            held_live  = 1'b0;
            rpt_open   = 1'b0;
            rpt_val    = '0;
            past_point = 1'b0;
            dig_acc    = '0;
            scl_acc    = '0;
            sign_flag  = 1'b0;
            cls_acc    = pcp_pkg::CLASS_ALNUM;
        end
    endfunction

    function automatic logic idle_roll(input pace_t p, input logic sink);
        int unsigned pct;
        case (p)
            PACE_SLOW_SRC:  pct = sink ? 0 : 78;
            PACE_SLOW_SINK: pct = sink ? 78 : 0;
            PACE_BOTH:      pct = 26;
            default:        pct = 0;
        endcase
        return $urandom_range(99) < pct;
    endfunction

    // Moves the characters of one picture string to the send queue and marks
    // the final one as last.
    function void flush_text(input pace_t p);
        foreach (text_buf[i])
            char_q.push_back('{ch: text_buf[i], last: (i == text_buf.size() - 1), pace: p});
        queued_total += text_buf.size();
        text_buf.delete();
    endfunction

    function void queue_text(input string s);
        for (int i = 0; i < s.len(); i++)
            text_buf.push_back(s[i]);
        flush_text(PACE_STEADY);
    endfunction

    function void build_picture();
        string      syms;
        logic [7:0] c;
        int         roll;
        int         n_dig;
        syms = "99XASVZ*+-,./";
        repeat ($urandom_range(6, 1))
        begin
            c = syms[$urandom_range(syms.len() - 1)];
            if (c >= pcp_pkg::ChA && c <= pcp_pkg::ChZ && $urandom_range(3) == 0)
                c = c + pcp_pkg::CaseGap;
            text_buf.push_back(c);
            if ($urandom_range(9) < 4)
            begin
                text_buf.push_back(pcp_pkg::ChOpen);
                roll  = $urandom_range(19);
                n_dig = (roll == 0) ? 0 : (roll == 1) ? 5 : $urandom_range(2, 1);
                repeat (n_dig)
                    text_buf.push_back(pcp_pkg::ChZero + 8'($urandom_range(9)));
                // Now and then the count is left open.
                if ($urandom_range(9) != 0)
                    text_buf.push_back(pcp_pkg::ChClose);
            end
        end
    endfunction

    function void build_noise();
        repeat ($urandom_range(8, 1))
            case ($urandom_range(3))
                0:       text_buf.push_back(pcp_pkg::ChOpen);
                1:       text_buf.push_back(pcp_pkg::ChZero + 8'($urandom_range(9)));
                default: text_buf.push_back(8'($urandom_range(255)));
            endcase
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sym_valid   <= 1'b0;
            symbol_char <= '0;
            last_char   <= 1'b0;
        end
        else if (!sym_valid || sym_ready)
        begin
            if (char_q.size() != 0 && !idle_roll(char_q[0].pace, 1'b0))
            begin
                sym_valid   <= 1'b1;
                symbol_char <= char_q[0].ch;
                last_char   <= char_q[0].last;
                cur_pace    <= char_q[0].pace;
                void'(char_q.pop_front());
            end
            else
                sym_valid <= 1'b0;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_ready <= 1'b0;
        else
            res_ready <= !idle_roll(cur_pace, 1'b1);
    end

    always @(posedge clk)
    begin : watch
        pic_summary_t want;
        if (rst_n)
        begin
            if (res_valid && res_ready)
            begin
                result_total++;
                if (summary_q.size() == 0)
                begin
                    mismatch_total++;
                    if (mismatch_total <= ShowLimit)
                    begin
                        $write("result %0d with nothing expected: ", result_total);
                        $display("class %0d digits %0d scale %0d sign %0b size %0d",
                                 pic_class, digit_count, scale_count,
                                 has_sign, total_size);
                    end
                end
                else
                begin
                    want = summary_q.pop_front();
                    if (pic_class !== want.cls || digit_count !== want.digits ||
                        scale_count !== want.scale || has_sign !== want.sign ||
                        total_size !== want.size)
                    begin
                        mismatch_total++;
                        if (mismatch_total <= ShowLimit)
                        begin
                            $write("result %0d: expected class %0d digits %0d ",
                                   result_total, want.cls, want.digits);
                            $write("scale %0d sign %0b size %0d, ",
                                   want.scale, want.sign, want.size);
                            $write("got class %0d digits %0d ", pic_class, digit_count);
                            $display("scale %0d sign %0b size %0d",
                                     scale_count, has_sign, total_size);
                        end
                    end
                end
            end
            if (sym_valid && sym_ready)
            begin
                accepted_total++;
                predict_char(symbol_char, last_char);
            end
        end
    end

    initial
    begin
        int rand_base;
        // Paren with nothing pending, folded sign, saturated count and size.
        queue_text("(s9(99999)");
        // Point, then a count closed by a letter instead of a paren.
        queue_text("v9(2x");
        // Empty count.
        queue_text("A()");
        // Stray close paren, folded edit symbol, bytes at both ends of the range.
        text_buf = '{pcp_pkg::ChClose, pcp_pkg::ChLowZ, 8'hFF, 8'h00};
        flush_text(PACE_STEADY);
        // String ends inside a count.
        queue_text("9(1");
        rand_base = queued_total;
        while (queued_total - rand_base < RandChars)
        begin
            if ($urandom_range(9) < 8)
                build_picture();
            else
                build_noise();
            flush_text(pace_t'((queued_total - rand_base) * 4 / RandChars));
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        while (accepted_total < queued_total || summary_q.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);

        if (mismatch_total == 0 && summary_q.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/pcp_pkg.sv
hw/rtl/picture_clause_parser_top.sv
tb/sv/picture_clause_parser_top_tb.sv
